// ===== hw/rtl/rws_pkg.sv =====
// rws_pkg: shared widths, codes, types and helpers of the roulette wheel selector
// no dependencies; used by every module of the block but rws_ram
`default_nettype none

package rws_pkg;

    // sizing of the block
    localparam int MAX_POPULATION = 256;
    localparam int FITNESS_BITS   = 32;
    localparam int DRAW_BITS      = 16;

    // fixed port widths
    localparam int CFG_BITS       = 9;
    localparam int IN_FIT_BITS    = 32;
    localparam int IN_DRAW_BITS   = 16;
    localparam int OUT_IDX_BITS   = 8;
    localparam int OUT_FIT_BITS   = 32;
    localparam int TOTAL_BITS     = 40;
    localparam int AVG_BITS       = 32;

    // derived widths
    localparam int IDX_BITS       = $clog2(MAX_POPULATION);
    localparam int SIZE_BITS      = IDX_BITS + 1;
    localparam int REM_BITS       = SIZE_BITS;
    localparam int THR_BITS       = TOTAL_BITS + DRAW_BITS;
    localparam int DIV_CELLS      = AVG_BITS;

    localparam logic [CFG_BITS-1:0] POP_RESET = CFG_BITS'(256);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_SELECT  = 1'b1;
    localparam logic KIND_STATS  = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LAUNCH,
        ST_DIV_WAIT,
        ST_SEL_MUL,
        ST_SEL_WALK
    } t_state;

    // one divider cell's view of a division in flight
    typedef struct packed {
        logic                 valid;
        logic [REM_BITS-1:0]  rem;
        logic [AVG_BITS-1:0]  dq;
        logic [SIZE_BITS-1:0] div;
    } t_div_lane;

    // saturating accumulate of one fitness value into a total
    function automatic logic [TOTAL_BITS-1:0] sat_add(
        input logic [TOTAL_BITS-1:0]   a,
        input logic [FITNESS_BITS-1:0] b
    );
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + (TOTAL_BITS + 1)'(b);
        return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rws_ram.sv =====
// rws_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/rws_div_cell.sv =====
// rws_div_cell: one restoring division step, registered, passes its lane onward
// depends on rws_pkg
`default_nettype none

module rws_div_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rws_pkg::t_div_lane i_lane,
    output rws_pkg::t_div_lane      o_lane
);

    logic                          r_valid;
    logic [rws_pkg::REM_BITS-1:0]  r_rem;
    logic [rws_pkg::AVG_BITS-1:0]  r_dq;
    logic [rws_pkg::SIZE_BITS-1:0] r_div;

    logic [rws_pkg::REM_BITS:0]    shifted;
    logic [rws_pkg::REM_BITS:0]    div_ext;
    logic                          ge;
    logic [rws_pkg::REM_BITS-1:0]  n_rem;
    logic [rws_pkg::AVG_BITS-1:0]  n_dq;

    always_comb begin
        // bring down the next dividend bit
        shifted = {i_lane.rem, i_lane.dq[rws_pkg::AVG_BITS-1]};
        div_ext = (rws_pkg::REM_BITS + 1)'(i_lane.div);
        ge      = (shifted >= div_ext);
        n_rem   = ge ? rws_pkg::REM_BITS'(shifted - div_ext)
                     : rws_pkg::REM_BITS'(shifted);
        n_dq    = {i_lane.dq[rws_pkg::AVG_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_div <= i_lane.div;
    end

    always_comb begin
        o_lane.valid = r_valid;
        o_lane.rem   = r_rem;
        o_lane.dq    = r_dq;
        o_lane.div   = r_div;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rws_div_chain.sv =====
// rws_div_chain: row of divider cells, one quotient bit per cell per cycle
// depends on rws_pkg and rws_div_cell
`default_nettype none

module rws_div_chain (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rws_pkg::t_div_lane i_lane,
    output rws_pkg::t_div_lane      o_lane
);

    rws_pkg::t_div_lane             lanes [rws_pkg::DIV_CELLS+1];
    logic [rws_pkg::DIV_CELLS-1:0]  valid_vec;

    assign lanes[0] = i_lane;

    for (genvar k = 0; k < rws_pkg::DIV_CELLS; k++) begin : g_cell
        rws_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_lane (lanes[k]),
            .o_lane (lanes[k+1])
        );
        assign valid_vec[k] = lanes[k+1].valid;
    end

    assign o_lane = lanes[rws_pkg::DIV_CELLS];

    // only one division is ever in flight
    a_single_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(valid_vec))
        else $error("more than one division in the divider chain");

endmodule

`default_nettype wire

// ===== hw/rtl/roulette_wheel_selector.sv =====
// roulette_wheel_selector: top level, command control, statistics and selection walk
// depends on rws_pkg, rws_ram and rws_div_chain
// load: busy-free unless it fills the population; that load starts the divider
//   chain, stays busy and strobes its statistics once the last divider cell is done
// select: ST_SEL_MUL scales the draw, then ST_SEL_WALK reads slots 0..k, k the chosen slot
//   (at most n-1), one slot per cycle from the single RAM read port; busy until the strobe
// results are strobed for one cycle and cannot be stalled
// synchronous active-low reset clears counters and statistics; the store is not cleared
`default_nettype none

module roulette_wheel_selector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cmd,
    input  wire logic [rws_pkg::IN_FIT_BITS-1:0]   i_fitness_value,
    input  wire logic [rws_pkg::IN_DRAW_BITS-1:0]  i_draw,
    // configuration channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rws_pkg::CFG_BITS-1:0]      i_cfg_data,
    // results
    output logic                                   o_strobe,
    output logic                                   o_kind,
    output logic [rws_pkg::OUT_IDX_BITS-1:0]       o_chosen_index,
    output logic [rws_pkg::TOTAL_BITS-1:0]         o_total_fitness,
    output logic [rws_pkg::OUT_FIT_BITS-1:0]       o_highest_fitness,
    output logic [rws_pkg::OUT_IDX_BITS-1:0]       o_fittest_index,
    output logic [rws_pkg::OUT_FIT_BITS-1:0]       o_lowest_fitness,
    output logic [rws_pkg::OUT_FIT_BITS-1:0]       o_average_fitness
);

    rws_pkg::t_state                  r_state, n_state;

    logic [rws_pkg::CFG_BITS-1:0]     r_pop;
    logic [rws_pkg::SIZE_BITS-1:0]    r_load_count, n_load_count;
    logic [rws_pkg::TOTAL_BITS-1:0]   r_total, n_total;
    logic [rws_pkg::FITNESS_BITS-1:0] r_high, n_high;
    logic [rws_pkg::FITNESS_BITS-1:0] r_low, n_low;
    logic [rws_pkg::IDX_BITS-1:0]     r_best, n_best;

    logic [rws_pkg::DRAW_BITS-1:0]    r_draw;
    logic [rws_pkg::THR_BITS-1:0]     r_thr;
    logic [rws_pkg::TOTAL_BITS-1:0]   r_cum, n_cum;
    logic [rws_pkg::IDX_BITS-1:0]     r_walk_idx;

    logic                             r_strobe;
    logic                             r_kind;
    logic [rws_pkg::OUT_IDX_BITS-1:0] r_chosen;
    logic [rws_pkg::TOTAL_BITS-1:0]   r_out_total;
    logic [rws_pkg::OUT_FIT_BITS-1:0] r_out_high;
    logic [rws_pkg::OUT_IDX_BITS-1:0] r_out_best;
    logic [rws_pkg::OUT_FIT_BITS-1:0] r_out_low;
    logic [rws_pkg::OUT_FIT_BITS-1:0] r_out_avg;

    logic [rws_pkg::SIZE_BITS-1:0]    eff_n;
    logic                             load_go;
    logic                             sel_go;
    logic [rws_pkg::FITNESS_BITS-1:0] fit_v;
    logic [rws_pkg::IDX_BITS-1:0]     slot;
    logic                             stats_done;
    logic [rws_pkg::SIZE_BITS-1:0]    cnt_inc;
    logic                             first_load;

    logic                             div_launch;
    rws_pkg::t_div_lane               div_in;
    rws_pkg::t_div_lane               div_out;
    logic                             avg_sat;

    logic [rws_pkg::IDX_BITS-1:0]     ram_raddr;
    logic [rws_pkg::FITNESS_BITS-1:0] ram_rdata;
    logic                             hit;
    logic                             last_slot;
    logic                             walk_end;

    // size register as used: zero acts as one, large values clamp
    always_comb begin
        if (r_pop == '0) begin
            eff_n = rws_pkg::SIZE_BITS'(1);
        end else if (32'(r_pop) > 32'(rws_pkg::MAX_POPULATION)) begin
            eff_n = rws_pkg::SIZE_BITS'(rws_pkg::MAX_POPULATION);
        end else begin
            eff_n = rws_pkg::SIZE_BITS'(r_pop);
        end
    end

    assign load_go = start && !busy && (i_cmd == rws_pkg::CMD_LOAD);
    assign sel_go  = start && !busy && (i_cmd == rws_pkg::CMD_SELECT);

    // statistics update for one load
    always_comb begin
        fit_v      = rws_pkg::FITNESS_BITS'(i_fitness_value);
        slot       = r_load_count[rws_pkg::IDX_BITS-1:0];
        first_load = (r_load_count == '0);
        n_total    = first_load ? '0 : r_total;
        n_high     = first_load ? '0 : r_high;
        n_low      = first_load ? '1 : r_low;
        n_best     = first_load ? '0 : r_best;
        if (fit_v > n_high) begin
            n_high = fit_v;
            n_best = slot;
        end
        if (fit_v < n_low) begin
            n_low = fit_v;
        end
        n_total      = rws_pkg::sat_add(n_total, fit_v);
        cnt_inc      = r_load_count + rws_pkg::SIZE_BITS'(1);
        stats_done   = (cnt_inc >= eff_n);
        n_load_count = stats_done ? '0 : cnt_inc;
    end

    // selection walk step: ram_rdata holds slot r_walk_idx
    always_comb begin
        n_cum     = rws_pkg::sat_add(r_cum, ram_rdata);
        hit       = ({n_cum, rws_pkg::DRAW_BITS'(0)} >= r_thr);
        last_slot = (rws_pkg::SIZE_BITS'(r_walk_idx) == (eff_n - rws_pkg::SIZE_BITS'(1)));
        walk_end  = hit || last_slot;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rws_pkg::ST_IDLE: begin
                if (load_go && stats_done) begin
                    n_state = rws_pkg::ST_DIV_LAUNCH;
                end else if (sel_go) begin
                    n_state = rws_pkg::ST_SEL_MUL;
                end
            end
            rws_pkg::ST_DIV_LAUNCH: begin
                n_state = rws_pkg::ST_DIV_WAIT;
            end
            rws_pkg::ST_DIV_WAIT: begin
                if (div_out.valid) begin
                    n_state = rws_pkg::ST_IDLE;
                end
            end
            rws_pkg::ST_SEL_MUL: begin
                n_state = rws_pkg::ST_SEL_WALK;
            end
            rws_pkg::ST_SEL_WALK: begin
                if (walk_end) begin
                    n_state = rws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rws_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy       = 1'b1;
        div_launch = 1'b0;
        ram_raddr  = '0;
        unique case (r_state)
            rws_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            rws_pkg::ST_DIV_LAUNCH: begin
                div_launch = 1'b1;
            end
            rws_pkg::ST_DIV_WAIT: begin
                busy = 1'b1;
            end
            rws_pkg::ST_SEL_MUL: begin
                ram_raddr = '0;
            end
            rws_pkg::ST_SEL_WALK: begin
                // prefetch the next slot
                ram_raddr = r_walk_idx + rws_pkg::IDX_BITS'(1);
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rws_pkg::ST_IDLE;
            r_pop        <= rws_pkg::POP_RESET;
            r_load_count <= '0;
            r_total      <= '0;
            r_high       <= '0;
            r_low        <= '1;
            r_best       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pop <= i_cfg_data;
            end
            if (load_go) begin
                r_load_count <= n_load_count;
                r_total      <= n_total;
                r_high       <= n_high;
                r_low        <= n_low;
                r_best       <= n_best;
            end
        end
    end

    // selection datapath
    always_ff @(posedge i_clk) begin
        if (sel_go) begin
            r_draw <= rws_pkg::DRAW_BITS'(i_draw);
        end
        if (r_state == rws_pkg::ST_SEL_MUL) begin
            r_thr      <= rws_pkg::THR_BITS'(r_total) * rws_pkg::THR_BITS'(r_draw);
            r_cum      <= '0;
            r_walk_idx <= '0;
        end else if (r_state == rws_pkg::ST_SEL_WALK) begin
            r_cum      <= n_cum;
            r_walk_idx <= r_walk_idx + rws_pkg::IDX_BITS'(1);
        end
    end

    rws_ram #(
        .WIDTH(rws_pkg::FITNESS_BITS),
        .DEPTH(rws_pkg::MAX_POPULATION)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (load_go),
        .i_waddr(slot),
        .i_wdata(fit_v),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // average: the top bits of the total seed the remainder
    always_comb begin
        div_in.valid = div_launch;
        div_in.rem   = rws_pkg::REM_BITS'(r_total[rws_pkg::TOTAL_BITS-1:rws_pkg::AVG_BITS]);
        div_in.dq    = r_total[rws_pkg::AVG_BITS-1:0];
        div_in.div   = eff_n;
        avg_sat      = (32'(r_total[rws_pkg::TOTAL_BITS-1:rws_pkg::AVG_BITS]) >= 32'(eff_n));
    end

    rws_div_chain u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_lane (div_in),
        .o_lane (div_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ((r_state == rws_pkg::ST_DIV_WAIT) && div_out.valid)
                     || ((r_state == rws_pkg::ST_SEL_WALK) && walk_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == rws_pkg::ST_DIV_WAIT) && div_out.valid) begin
            r_kind      <= rws_pkg::KIND_STATS;
            r_chosen    <= '0;
            r_out_total <= r_total;
            r_out_high  <= rws_pkg::OUT_FIT_BITS'(r_high);
            r_out_best  <= rws_pkg::OUT_IDX_BITS'(r_best);
            r_out_low   <= rws_pkg::OUT_FIT_BITS'(r_low);
            r_out_avg   <= avg_sat ? '1 : rws_pkg::OUT_FIT_BITS'(div_out.dq);
        end else if ((r_state == rws_pkg::ST_SEL_WALK) && walk_end) begin
            r_kind      <= rws_pkg::KIND_SELECT;
            r_chosen    <= rws_pkg::OUT_IDX_BITS'(r_walk_idx);
            r_out_total <= '0;
            r_out_high  <= '0;
            r_out_best  <= '0;
            r_out_low   <= '0;
            r_out_avg   <= '0;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_kind            = r_kind;
    assign o_chosen_index    = r_chosen;
    assign o_total_fitness   = r_out_total;
    assign o_highest_fitness = r_out_high;
    assign o_fittest_index   = r_out_best;
    assign o_lowest_fitness  = r_out_low;
    assign o_average_fitness = r_out_avg;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == rws_pkg::ST_IDLE))
        else $error("result strobe while a command is still in progress");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rws_pkg::ST_SEL_WALK) |-> (32'(r_walk_idx) < 32'(eff_n)))
        else $error("selection walk past the population");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_out.valid |-> (r_state == rws_pkg::ST_DIV_WAIT))
        else $error("division finished outside its wait state");

    a_stats_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rws_pkg::ST_DIV_LAUNCH) |-> ##(rws_pkg::DIV_CELLS + 1) r_strobe)
        else $error("statistics result not strobed after the divider chain");

endmodule

`default_nettype wire

// ===== tb/rws_checker.sv =====
// rws_checker: watches the command, configuration and result ports of the roulette wheel
// selector, predicts statistics and selections, and compares every result strobe
// depends on rws_pkg
module rws_checker
    import rws_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    input  wire logic                     busy,
    input  wire logic                     i_cmd,
    input  wire logic [IN_FIT_BITS-1:0]   i_fitness_value,
    input  wire logic [IN_DRAW_BITS-1:0]  i_draw,
    input  wire logic                     i_cfg_valid,
    input  wire logic                     o_cfg_ready,
    input  wire logic [CFG_BITS-1:0]      i_cfg_data,
    input  wire logic                     o_strobe,
    input  wire logic                     o_kind,
    input  wire logic [OUT_IDX_BITS-1:0]  o_chosen_index,
    input  wire logic [TOTAL_BITS-1:0]    o_total_fitness,
    input  wire logic [OUT_FIT_BITS-1:0]  o_highest_fitness,
    input  wire logic [OUT_IDX_BITS-1:0]  o_fittest_index,
    input  wire logic [OUT_FIT_BITS-1:0]  o_lowest_fitness,
    input  wire logic [OUT_FIT_BITS-1:0]  o_average_fitness,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic                    kind;
        logic [OUT_IDX_BITS-1:0] chosen;
        logic [TOTAL_BITS-1:0]   total;
        logic [OUT_FIT_BITS-1:0] highest;
        logic [OUT_IDX_BITS-1:0] fittest;
        logic [OUT_FIT_BITS-1:0] lowest;
        logic [OUT_FIT_BITS-1:0] average;
    } t_outcome;

    t_outcome outcome_q[$];
    int mismatches = 0;
    int queued = 0;

    // mirror of the block's state
    logic [FITNESS_BITS-1:0] slot_fit [MAX_POPULATION];
    logic [CFG_BITS-1:0]     pop_size;
    logic [SIZE_BITS-1:0]    loads_done;
    logic [TOTAL_BITS-1:0]   fit_total;
    logic [FITNESS_BITS-1:0] top_fit;
    logic [FITNESS_BITS-1:0] low_fit;
    logic [IDX_BITS-1:0]     top_slot;

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    function automatic int unsigned active_size();
        if (pop_size == 0) return 1;
        if (pop_size > MAX_POPULATION) return MAX_POPULATION;
        return int'(pop_size);
    endfunction

    function automatic logic [TOTAL_BITS-1:0] clamp_sum(
        input logic [TOTAL_BITS-1:0]   acc,
        input logic [FITNESS_BITS-1:0] v
    );
        logic [TOTAL_BITS:0] s;
        s = {1'b0, acc} + {{(TOTAL_BITS + 1 - FITNESS_BITS){1'b0}}, v};
        return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
    endfunction

    task automatic absorb_load(input logic [FITNESS_BITS-1:0] v);
        t_outcome r;
        int unsigned n;
        logic [TOTAL_BITS-1:0] avg;
        n = active_size();
        // first load of a population restarts the statistics
        if (loads_done == 0) begin
            fit_total = '0;
            top_fit   = '0;
            low_fit   = '1;
            top_slot  = '0;
        end
        slot_fit[loads_done[IDX_BITS-1:0]] = v;
        if (v > top_fit) begin
            top_fit  = v;
            top_slot = loads_done[IDX_BITS-1:0];
        end
        if (v < low_fit) low_fit = v;
        fit_total  = clamp_sum(fit_total, v);
        loads_done = loads_done + 1'b1;
        if (loads_done >= n) begin
            loads_done = '0;
            avg = fit_total / TOTAL_BITS'(n);
            r = '0;
            r.kind    = KIND_STATS;
            r.total   = fit_total;
            r.highest = top_fit;
            r.fittest = top_slot;
            r.lowest  = low_fit;
            r.average = (avg > {AVG_BITS{1'b1}}) ? {AVG_BITS{1'b1}} : avg[AVG_BITS-1:0];
            outcome_q = {outcome_q, r};
        end
    endtask

    task automatic predict_pick(input logic [IN_DRAW_BITS-1:0] d);
        t_outcome r;
        int unsigned n;
        int unsigned pick;
        int unsigned i;
        bit hit;
        logic [THR_BITS-1:0]   target;
        logic [TOTAL_BITS-1:0] cum;
        n      = active_size();
        pick   = n - 1;
        hit    = 1'b0;
        cum    = '0;
        target = THR_BITS'(fit_total) * THR_BITS'(d);
        for (i = 0; i < n && !hit; i++) begin
            cum = clamp_sum(cum, slot_fit[i]);
            if ({cum, {DRAW_BITS{1'b0}}} >= target) begin
                pick = i;
                hit  = 1'b1;
            end
        end
        r = '0;
        r.kind   = KIND_SELECT;
        r.chosen = pick[OUT_IDX_BITS-1:0];
        outcome_q = {outcome_q, r};
    endtask

    task automatic check_field(input string what, input logic [TOTAL_BITS-1:0] want,
                               input logic [TOTAL_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            outcome_q.delete();
            pop_size   = POP_RESET;
            loads_done = '0;
            fit_total  = '0;
            top_fit    = '0;
            low_fit    = '1;
            top_slot   = '0;
        end else begin
            // compare before predicting so a stray strobe never eats a fresh expectation
            if (o_strobe) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result strobe with nothing expected, kind %0b",
                             $time, o_kind);
                    mismatches++;
                end else begin
                    t_outcome e;
                    e = outcome_q.pop_front();
                    check_field("kind", e.kind, o_kind);
                    check_field("chosen_index", e.chosen, o_chosen_index);
                    check_field("total_fitness", e.total, o_total_fitness);
                    check_field("highest_fitness", e.highest, o_highest_fitness);
                    check_field("fittest_index", e.fittest, o_fittest_index);
                    check_field("lowest_fitness", e.lowest, o_lowest_fitness);
                    check_field("average_fitness", e.average, o_average_fitness);
                end
            end
            if (i_cfg_valid && o_cfg_ready) pop_size = i_cfg_data;
            if (start && !busy) begin
                if (i_cmd == CMD_LOAD) absorb_load(i_fitness_value[FITNESS_BITS-1:0]);
                else predict_pick(i_draw);
            end
        end
        queued <= outcome_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for the roulette wheel selector
// depends on rws_pkg, roulette_wheel_selector and rws_checker
module tb;
    import rws_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    i_cmd = CMD_LOAD;
    logic [IN_FIT_BITS-1:0]  i_fitness_value = '0;
    logic [IN_DRAW_BITS-1:0] i_draw = '0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    logic                    busy;
    logic                    o_cfg_ready;
    logic                    o_strobe;
    logic                    o_kind;
    logic [OUT_IDX_BITS-1:0] o_chosen_index;
    logic [TOTAL_BITS-1:0]   o_total_fitness;
    logic [OUT_FIT_BITS-1:0] o_highest_fitness;
    logic [OUT_IDX_BITS-1:0] o_fittest_index;
    logic [OUT_FIT_BITS-1:0] o_lowest_fitness;
    logic [OUT_FIT_BITS-1:0] o_average_fitness;

    int fail_count;
    int pending;

    // stimulus-side bookkeeping: which slots hold a value, where the next load lands
    logic [MAX_POPULATION-1:0] filled = '0;
    int issued = 0;
    int next_slot = 0;
    int pop_n = MAX_POPULATION;
    bit steady = 1'b0;

    roulette_wheel_selector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_fitness_value   (i_fitness_value),
        .i_draw            (i_draw),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_kind            (o_kind),
        .o_chosen_index    (o_chosen_index),
        .o_total_fitness   (o_total_fitness),
        .o_highest_fitness (o_highest_fitness),
        .o_fittest_index   (o_fittest_index),
        .o_lowest_fitness  (o_lowest_fitness),
        .o_average_fitness (o_average_fitness)
    );

    rws_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_fitness_value   (i_fitness_value),
        .i_draw            (i_draw),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_kind            (o_kind),
        .o_chosen_index    (o_chosen_index),
        .o_total_fitness   (o_total_fitness),
        .o_highest_fitness (o_highest_fitness),
        .o_fittest_index   (o_fittest_index),
        .o_lowest_fitness  (o_lowest_fitness),
        .o_average_fitness (o_average_fitness),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [IN_FIT_BITS-1:0] fv,
                             input logic [IN_DRAW_BITS-1:0] dr);
        while (!steady && $urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_fitness_value <= fv;
        i_draw          <= dr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
    endtask

    task automatic load_one(input logic [IN_FIT_BITS-1:0] v);
        send_item(CMD_LOAD, v, IN_DRAW_BITS'($urandom));
        filled[next_slot] = 1'b1;
        next_slot++;
        if (next_slot >= pop_n) next_slot = 0;
    endtask

    task automatic pick_one(input logic [IN_DRAW_BITS-1:0] d);
        send_item(CMD_SELECT, $urandom, d);
    endtask

    // a select walks slots 0..n-1, so each of them must have been loaded once
    function automatic bit walk_safe();
        for (int i = 0; i < pop_n; i++) begin
            if (!filled[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // wait for every expected result, then for the statistics latency of a silent load
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_BITS-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (v == 0) pop_n = 1;
        else if (v > MAX_POPULATION) pop_n = MAX_POPULATION;
        else pop_n = int'(v);
    endtask

    function automatic logic [IN_FIT_BITS-1:0] rand_fitness();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            3: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_size();
        case ($urandom_range(0, 39))
            0: return '0;
            1: begin
                case ($urandom_range(0, 2))
                    0: return CFG_BITS'(256);
                    1: return CFG_BITS'(300);
                    default: return '1;
                endcase
            end
            2, 3, 4, 5: return CFG_BITS'($urandom_range(13, 48));
            default: return CFG_BITS'($urandom_range(1, 12));
        endcase
    endfunction

    initial begin
        int wait_cycles;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, strict highest on a tie, draws at both ends
        write_size(4);
        load_one('0);
        load_one('1);
        load_one('1);
        load_one(1);
        pick_one('0);
        pick_one('1);
        pick_one(16'h8000);
        pick_one(1);
        // population of one
        write_size(1);
        load_one(5);
        pick_one('0);
        pick_one('1);
        // size zero acts as one; all-zero total always picks slot zero
        write_size(0);
        load_one('0);
        pick_one(16'h8000);
        // size lowered partway through a load pass
        write_size(8);
        load_one(7);
        load_one(7);
        load_one(7);
        write_size(2);
        load_one(9);
        pick_one(16'h4000);
        pick_one(16'hc000);
        // select while a pass is open, total is still partial
        write_size(3);
        load_one(1);
        pick_one('1);
        load_one(2);
        load_one(3);

        // size above the maximum clamps, one full-width pass
        write_size('1);
        load_one(rand_fitness());
        while (next_slot != 0) load_one(rand_fitness());
        repeat (4) pick_one(IN_DRAW_BITS'($urandom));

        while (issued < 900) begin
            int phase;
            steady = (issued >= 400 && issued < 560);
            phase = $urandom_range(0, 9);
            if (phase <= 6) begin
                if ($urandom_range(0, 1)) write_size(rand_size());
                load_one(rand_fitness());
                while (next_slot != 0) load_one(rand_fitness());
                if (walk_safe()) repeat ($urandom_range(1, 8)) pick_one(IN_DRAW_BITS'($urandom));
            end else if (phase == 7) begin
                // partial pass followed by selects over an open population
                if (pop_n > 1) repeat ($urandom_range(1, pop_n - 1)) load_one(rand_fitness());
                if (walk_safe()) repeat ($urandom_range(1, 4)) pick_one(IN_DRAW_BITS'($urandom));
            end else if (phase == 8) begin
                repeat ($urandom_range(2, 10)) begin
                    if (walk_safe() && $urandom_range(0, 1)) pick_one(IN_DRAW_BITS'($urandom));
                    else load_one(rand_fitness());
                end
            end else if (next_slot > 0) begin
                // shrink to at most the loads already done, next load closes the pass
                write_size(CFG_BITS'($urandom_range(1, next_slot)));
                load_one(rand_fitness());
            end
        end
        steady = 1'b0;

        start <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== roulette_wheel_selector.f =====
hw/rtl/rws_pkg.sv
hw/rtl/rws_ram.sv
hw/rtl/rws_div_cell.sv
hw/rtl/rws_div_chain.sv
hw/rtl/roulette_wheel_selector.sv
tb/rws_checker.sv
tb/tb.sv
